// ===== rtl/core/class_filtered_unique_word_collector_assert.svh =====
// Assertion macros used by the word collector RTL.
// Define NO_ASSERTIONS to compile the checks out; depends on i_clk and i_rst_n in scope.
`ifndef CLASS_FILTERED_UNIQUE_WORD_COLLECTOR_ASSERT_SVH
`define CLASS_FILTERED_UNIQUE_WORD_COLLECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that holds outside reset, sampled on the rising clock edge.
`define CFUWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that also holds while reset is applied.
`define CFUWC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`else

`define CFUWC_ASSERT(lbl, prop, msg)
`define CFUWC_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/cfuwc_pkg.sv =====
// Shared constants, types and helpers for the unique word collector.
// Used by the interfaces and every module of the block; depends on nothing.
package cfuwc_pkg;

    // Field widths.
    localparam int CHAR_W     = 8;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = CHAR_W * WORD_BYTES;
    localparam int LEN_W      = 4;
    localparam int SLOT_W     = 6;

    // Word and table sizing.
    localparam int MAX_WORD    = 8;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Character class maps and configuration register indexes.
    localparam int MAP_W     = 64;
    localparam int NUM_MAPS  = 4;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_BASE  = 3'd4;

    // Case folding.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    // Word queue between tokenizer and lookup engine.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One submitted word: packed bytes (unused bytes zero) and length.
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [LEN_W-1:0]  len;
    } t_word;

    // One lookup result.
    typedef struct packed {
        logic [WORD_W-1:0] bytes;
        logic [LEN_W-1:0]  len;
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        logic              table_full;
    } t_result;

    // Reports a table index in the slot field width (low bits only).
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = (IDX_W + SLOT_W)'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/cfuwc_in_if.sv =====
// Input channel of the word collector: one text byte or line end per transaction.
// Depends on cfuwc_pkg for the field widths.
interface cfuwc_in_if;
    logic                        valid;
    logic                        ready;
    logic [cfuwc_pkg::CHAR_W-1:0] char_code;
    logic                        line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

// ===== rtl/core/cfuwc_out_if.sv =====
// Output channel of the word collector: one lookup result per transaction.
// Depends on cfuwc_pkg for the field widths.
interface cfuwc_out_if;
    logic                         valid;
    logic                         ready;
    logic [cfuwc_pkg::WORD_W-1:0] word_bytes;
    logic [cfuwc_pkg::LEN_W-1:0]  word_length;
    logic                         is_new;
    logic [cfuwc_pkg::SLOT_W-1:0] slot;
    logic                         table_full;

    modport source (output valid, output word_bytes, output word_length, output is_new,
                    output slot, output table_full, input ready);
    modport sink   (input valid, input word_bytes, input word_length, input is_new,
                    input slot, input table_full, output ready);
endinterface

// ===== rtl/core/cfuwc_front.sv =====
// Tokenizer front end: holds the class maps, folds case, builds words a byte
// at a time and pushes finished words to the queue. Depends on cfuwc_pkg, cfuwc_in_if.
module cfuwc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cfuwc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfuwc_pkg::MAP_W-1:0]     i_cfg_wdata,
    cfuwc_in_if.sink                        i_item,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output cfuwc_pkg::t_word                o_q_word
);
    import cfuwc_pkg::*;

    logic [MAP_W-1:0]  r_allowed [NUM_MAPS];
    logic [MAP_W-1:0]  r_letter  [NUM_MAPS];
    logic [CHAR_W-1:0] r_buf     [WORD_BYTES];
    logic [LEN_W-1:0]  r_len;
    logic              r_valid;

    logic              accept;
    logic [CHAR_W-1:0] folded;
    logic              is_allowed;
    logic              is_letter;
    logic              do_append;
    logic              is_sep;

    // Configuration writes into the class maps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MAPS; m++) begin
                r_allowed[m] <= '0;
                r_letter[m]  <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_LETTER_BASE) begin
                r_allowed[i_cfg_idx[1:0]] <= i_cfg_wdata;
            end else begin
                r_letter[i_cfg_idx[1:0]] <= i_cfg_wdata;
            end
        end
    end

    // The queue only fills on a separator, but stalling on full keeps it simple.
    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && i_item.ready;

    // Fold upper case letters and classify the byte.
    always_comb begin
        folded = i_item.char_code;
        if (i_item.char_code >= CHAR_UPPER_A && i_item.char_code <= CHAR_UPPER_Z) begin
            folded = i_item.char_code + CASE_OFFSET;
        end
    end

    assign is_allowed = r_allowed[folded[7:6]][folded[5:0]];
    assign is_letter  = r_letter[folded[7:6]][folded[5:0]];
    assign do_append  = !i_item.line_end && r_valid && is_allowed;
    assign is_sep     = i_item.line_end || (!(r_valid && is_allowed) && !is_letter);

    // Word state: append, spoil on overlong or letter byte, restart on separator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b1;
        end else if (accept) begin
            if (do_append) begin
                if (r_len < LEN_W'(MAX_WORD)) begin
                    r_len <= r_len + 1'b1;
                end else begin
                    r_valid <= 1'b0;
                    r_len   <= '0;
                end
            end else if (is_sep) begin
                r_valid <= 1'b1;
                r_len   <= '0;
            end else begin
                r_valid <= 1'b0;
                r_len   <= '0;
            end
        end
    end

    // Byte storage for the current word.
    always_ff @(posedge i_clk) begin
        if (accept && do_append && r_len < LEN_W'(MAX_WORD)) begin
            r_buf[r_len[2:0]] <= folded;
        end
    end

    // Pack the word with bytes beyond its length forced to zero.
    always_comb begin
        o_q_word.len = r_len;
        for (int i = 0; i < WORD_BYTES; i++) begin
            o_q_word.bytes[i*CHAR_W +: CHAR_W] =
                (LEN_W'(i) < r_len) ? r_buf[i] : '0;
        end
    end

    assign o_q_push = accept && is_sep && r_valid && (r_len != '0);

endmodule

// ===== rtl/core/cfuwc_fifo.sv =====
// Short word queue that decouples the tokenizer from the table lookup.
// Depends on cfuwc_pkg for the word type and depth.
module cfuwc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cfuwc_pkg::t_word i_word,
    input  logic             i_pop,
    output cfuwc_pkg::t_word o_word,
    output logic             o_full,
    output logic             o_empty
);
    import cfuwc_pkg::*;

    t_word                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_mem[r_rd];

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

// ===== rtl/core/cfuwc_back.sv =====
// Lookup engine: scans the word table one entry at a time, inserts new words
// and registers the result. Depends on cfuwc_pkg, cfuwc_out_if and the assertion header.
`include "class_filtered_unique_word_collector_assert.svh"

module cfuwc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfuwc_pkg::t_word i_q_word,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    cfuwc_out_if.source      o_result
);
    import cfuwc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    t_word            r_table [TABLE_DEPTH];
    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_found;
    logic             r_ovalid;
    t_word            r_word;
    t_word            r_rd;
    logic [IDX_W-1:0] r_idx;
    t_result          r_res;

    logic pop;
    logic match;
    logic last;
    logic out_free;
    logic load;
    logic has_room;
    logic insert;

    assign pop      = (r_state == S_IDLE) && !i_q_empty;
    assign match    = (r_state == S_CMP) && (r_rd == r_word);
    assign last     = (r_state == S_CMP) && (CNT_W'(r_idx) + 1'b1 == r_count);
    assign out_free = !r_ovalid || o_result.ready;
    assign load     = (r_state == S_DONE) && out_free;
    assign has_room = r_count < CNT_W'(TABLE_DEPTH);
    assign insert   = load && !r_found && has_room;
    assign o_q_pop  = pop;

    // Sequencer, fill count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_result.ready && !load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_found <= 1'b0;
                        r_state <= (r_count == '0) ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (match) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else if (last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (insert) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Word under lookup and scan index.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_word <= i_q_word;
            r_idx  <= '0;
        end else if (r_state == S_CMP && !match && !last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Table memory: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rd <= r_table[r_idx];
        end
        if (insert) begin
            r_table[r_count[IDX_W-1:0]] <= r_word;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res.bytes      <= r_word.bytes;
            r_res.len        <= r_word.len;
            r_res.is_new     <= !r_found && has_room;
            r_res.table_full <= !r_found && !has_room;
            if (r_found) begin
                r_res.slot <= to_slot(r_idx);
            end else if (has_room) begin
                r_res.slot <= to_slot(r_count[IDX_W-1:0]);
            end else begin
                r_res.slot <= '0;
            end
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.word_bytes  = r_res.bytes;
    assign o_result.word_length = r_res.len;
    assign o_result.is_new      = r_res.is_new;
    assign o_result.slot        = r_res.slot;
    assign o_result.table_full  = r_res.table_full;

    `CFUWC_ASSERT(a_count_bound, r_count <= CNT_W'(TABLE_DEPTH), "table count past depth")
    `CFUWC_ASSERT(a_insert_grows, insert |=> r_count == $past(r_count) + 1'b1, "insert lost")
    `CFUWC_ASSERT(a_scan_range, r_state == S_CMP |-> CNT_W'(r_idx) < r_count, "scan past fill")
    `CFUWC_ASSERT(a_load_shows, load |=> r_ovalid, "result register not loaded")
    `CFUWC_ASSERT_RST(a_reset_idle, !i_rst_n |=> r_state == S_IDLE && !r_ovalid, "bad reset")

endmodule

// ===== rtl/core/class_filtered_unique_word_collector.sv =====
// Unique word collector. The input side takes one byte (or line end) per
// cycle and is stalled only when the four-entry word queue is full. Each
// finished word is then looked up by the engine, which compares the table
// entries one at a time until a hit or the end of the filled table (at most
// 64 entries); each entry is fetched by a registered read ahead of its
// compare. A result waits in an output register while the next word is
// looked up. The table needs no clearing after reset; a fill count marks the
// live entries. Configuration: registers 0..3 are the allowed maps, 4..7 the
// letter maps, bit k of map n standing for byte code 64*n+k.
module class_filtered_unique_word_collector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cfuwc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfuwc_pkg::MAP_W-1:0]     i_cfg_wdata,
    cfuwc_in_if.sink                        i_item,
    cfuwc_out_if.source                     o_result
);
    import cfuwc_pkg::*;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_word q_in_word;
    t_word q_out_word;

    // Tokenizer.
    cfuwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_word    (q_in_word)
    );

    // Word queue.
    cfuwc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .i_pop   (q_pop),
        .o_word  (q_out_word),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Table lookup and insert.
    cfuwc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_word  (q_out_word),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule

// ===== tb/word_collector_checker.sv =====
// Checker for the unique word collector: watches the register port and both channels,
// predicts every lookup result and compares it with the transaction the block returns.
// Depends on cfuwc_pkg and on the cfuwc_in_if and cfuwc_out_if interfaces.
module word_collector_checker
    import cfuwc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MAP_W-1:0]     i_cfg_wdata,
    cfuwc_in_if                  i_item,
    cfuwc_out_if                 i_result,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted copy of the class maps, the word being built and the word table.
    logic [MAP_W-1:0]  allowed_bits [NUM_MAPS];
    logic [MAP_W-1:0]  spoiler_bits [NUM_MAPS];
    logic [WORD_W-1:0] word_text;
    int                word_len;
    logic              word_ok;
    logic [WORD_W-1:0] dict_text [TABLE_DEPTH];
    logic [LEN_W-1:0]  dict_len  [TABLE_DEPTH];
    int                dict_fill;
    t_result           pending_lookups [$];
    int                fail_total;

    // Looks the finished word up in the table and inserts it if absent and room is left.
    function automatic t_result lookup_word();
        t_result r;
        int      hit;
        hit = -1;
        for (int i = 0; i < dict_fill; i++) begin
            if (hit < 0 && dict_text[i] == word_text && dict_len[i] == LEN_W'(word_len))
                hit = i;
        end
        r.bytes      = word_text;
        r.len        = LEN_W'(word_len);
        r.is_new     = 1'b0;
        r.slot       = '0;
        r.table_full = 1'b0;
        if (hit >= 0) begin
            r.slot = SLOT_W'(hit);
        end else if (dict_fill < TABLE_DEPTH) begin
            dict_text[dict_fill] = word_text;
            dict_len[dict_fill]  = LEN_W'(word_len);
            r.slot   = SLOT_W'(dict_fill);
            r.is_new = 1'b1;
            dict_fill++;
        end else begin
            r.table_full = 1'b1;
        end
        return r;
    endfunction

    // Classifies one accepted byte and queues a lookup result when a word is submitted.
    task automatic tokenize_byte(input logic [CHAR_W-1:0] code, input logic eol);
        logic [CHAR_W-1:0] c;
        logic              splits;
        c      = code;
        splits = 1'b1;
        if (!eol) begin
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                c = c + CASE_OFFSET;
            if (word_ok && allowed_bits[c[7:6]][c[5:0]]) begin
                splits = 1'b0;
                if (word_len < MAX_WORD) begin
                    word_text[CHAR_W*word_len +: CHAR_W] = c;
                    word_len++;
                end else begin
                    // One byte too many: the word is dropped rather than truncated.
                    word_ok   = 1'b0;
                    word_len  = 0;
                    word_text = '0;
                end
            end else if (spoiler_bits[c[7:6]][c[5:0]]) begin
                splits    = 1'b0;
                word_ok   = 1'b0;
                word_len  = 0;
                word_text = '0;
            end
        end
        if (splits) begin
            if (word_ok && word_len > 0)
                pending_lookups.push_back(lookup_word());
            word_ok   = 1'b1;
            word_len  = 0;
            word_text = '0;
        end
    endtask

    // Compares a returned transaction with the oldest predicted result.
    task automatic check_result();
        t_result got;
        t_result exp;
        got.bytes      = i_result.word_bytes;
        got.len        = i_result.word_length;
        got.is_new     = i_result.is_new;
        got.slot       = i_result.slot;
        got.table_full = i_result.table_full;
        if (pending_lookups.size() == 0) begin
            $display("%0t: unexpected result: actual bytes=%h len=%0d new=%b slot=%0d full=%b",
                     $time, got.bytes, got.len, got.is_new, got.slot, got.table_full);
            fail_total++;
        end else begin
            exp = pending_lookups.pop_front();
            if (got.bytes !== exp.bytes || got.len !== exp.len || got.is_new !== exp.is_new ||
                got.slot !== exp.slot || got.table_full !== exp.table_full) begin
                $display("%0t: result mismatch: expected bytes=%h len=%0d new=%b slot=%0d full=%b",
                         $time, exp.bytes, exp.len, exp.is_new, exp.slot, exp.table_full);
                $display("%0t:                    actual bytes=%h len=%0d new=%b slot=%0d full=%b",
                         $time, got.bytes, got.len, got.is_new, got.slot, got.table_full);
                fail_total++;
            end
        end
    endtask

    // Everything is sampled on the rising edge; results are checked before new bytes
    // are predicted since no result can come out in the cycle of its own byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MAPS; i++) begin
                allowed_bits[i] = '0;
                spoiler_bits[i] = '0;
            end
            word_text = '0;
            word_len  = 0;
            word_ok   = 1'b1;
            dict_fill = 0;
            pending_lookups.delete();
        end else begin
            if (i_result.valid && i_result.ready)
                check_result();
            if (i_cfg_we) begin
                if (i_cfg_idx >= CFG_LETTER_BASE)
                    spoiler_bits[i_cfg_idx[1:0]] = i_cfg_wdata;
                else
                    allowed_bits[i_cfg_idx[1:0]] = i_cfg_wdata;
            end
            if (i_item.valid && i_item.ready)
                tokenize_byte(i_item.char_code, i_item.line_end);
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_lookups.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the word collector testbench: clock, reset, map programming and byte stimulus.
// Instantiates the block beside word_collector_checker, which predicts and compares.
// Depends on cfuwc_pkg and the cfuwc_in_if and cfuwc_out_if interfaces.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfuwc_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int VOCAB_MAX   = 48;

    typedef enum {ROLE_WORD, ROLE_SPOILER, ROLE_SEPARATOR} byte_role_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [MAP_W-1:0]     cfg_wdata;
    logic                 quiet = 1'b0;
    int                   items_sent = 0;
    int                   fail_count;
    int                   pending;
    logic [MAP_W-1:0]     cur_allowed [NUM_MAPS];
    logic [MAP_W-1:0]     cur_spoiler [NUM_MAPS];
    t_word                vocab [$];

    cfuwc_in_if  item_ch ();
    cfuwc_out_if result_ch ();

    class_filtered_unique_word_collector DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    word_collector_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // Hard stop in case the block hangs or keeps results back.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: stall in about a third of the cycles unless a quiet stretch runs.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            result_ch.ready <= quiet || ($urandom_range(99) >= 32);
        end
    end

    function automatic logic word_bit(input logic [7:0] c);
        return cur_allowed[c[7:6]][c[5:0]];
    endfunction

    function automatic logic spoiler_bit(input logic [7:0] c);
        return cur_spoiler[c[7:6]][c[5:0]];
    endfunction

    // Draws a random byte of the given role under the current maps. Upper-case letters
    // are left out since they fold; returns 0 when no such byte turns up.
    function automatic logic pick_byte(input byte_role_e role, output logic [7:0] c);
        logic [7:0] t;
        logic       ok;
        c = '0;
        for (int n = 0; n < 256; n++) begin
            t = 8'($urandom_range(255));
            if (t >= CHAR_UPPER_A && t <= CHAR_UPPER_Z)
                continue;
            case (role)
                ROLE_WORD:    ok = word_bit(t);
                ROLE_SPOILER: ok = spoiler_bit(t) && !word_bit(t);
                default:      ok = !spoiler_bit(t) && !word_bit(t);
            endcase
            if (ok) begin
                c = t;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Offers one byte transaction, with random idle cycles ahead of it, and returns
    // at the falling edge after it was accepted.
    task automatic send_item(input logic [7:0] code, input logic eol);
        while (!quiet && $urandom_range(99) < 32) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.char_code <= code;
        item_ch.line_end  <= eol;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Lower-case letters go out in upper case now and then to exercise the folding.
    task automatic send_text_byte(input logic [7:0] c);
        if (c >= CHAR_UPPER_A + CASE_OFFSET && c <= CHAR_UPPER_Z + CASE_OFFSET &&
            $urandom_range(3) == 0)
            send_item(c - CASE_OFFSET, 1'b0);
        else
            send_item(c, 1'b0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_separator();
        logic [7:0] c;
        if ($urandom_range(2) == 0 || !pick_byte(ROLE_SEPARATOR, c))
            send_item(8'($urandom_range(255)), 1'b1);
        else
            send_item(c, 1'b0);
    endtask

    // Sends a fresh or a repeated word followed by a separator; with spoil set, a
    // spoiling byte is slipped in ahead of one of its bytes.
    task automatic send_word(input logic spoil);
        t_word      w;
        logic [7:0] c;
        logic       fresh;
        int         n;
        int         spoil_at;
        int         done;
        fresh = (vocab.size() == 0) || ($urandom_range(1) == 1);
        w     = '0;
        done  = 0;
        if (fresh) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(MAX_WORD + 2, MAX_WORD + 1)
                                         : $urandom_range(MAX_WORD, 1);
        end else begin
            w = vocab[$urandom_range(vocab.size() - 1)];
            n = int'(w.len);
        end
        spoil_at = spoil ? $urandom_range(n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == spoil_at && pick_byte(ROLE_SPOILER, c))
                send_item(c, 1'b0);
            if (fresh) begin
                if (!pick_byte(ROLE_WORD, c))
                    break;
                if (i < MAX_WORD)
                    w.bytes[CHAR_W*i +: CHAR_W] = c;
            end else begin
                c = w.bytes[CHAR_W*i +: CHAR_W];
            end
            send_text_byte(c);
            done++;
        end
        if (fresh && done == n && n <= MAX_WORD && vocab.size() < VOCAB_MAX) begin
            w.len = LEN_W'(n);
            vocab.push_back(w);
        end
        send_separator();
    endtask

    // Mostly well-formed words, some spoiled ones and some raw noise bytes.
    task automatic random_stretch(input int count);
        int stop;
        int kind;
        stop = items_sent + count;
        while (items_sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 60)
                send_word(1'b0);
            else if (kind < 78)
                send_word(1'b1);
            else
                repeat ($urandom_range(3, 1))
                    send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    // Waits until the block is idle, then writes all eight map registers.
    task automatic apply_maps();
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        for (int i = 0; i < NUM_MAPS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_ALLOWED_BASE + CFG_IDX_W'(i);
            cfg_wdata <= cur_allowed[i];
            @(negedge clk);
        end
        for (int i = 0; i < NUM_MAPS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_LETTER_BASE + CFG_IDX_W'(i);
            cfg_wdata <= cur_spoiler[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Text maps: digits, lower-case letters and underscore form words; apostrophe,
    // hyphen, at-sign and every byte from 128 up spoil them.
    task automatic set_text_maps();
        cur_allowed[0] = 64'h03FF_0000_0000_0000;
        cur_allowed[1] = 64'h07FF_FFFE_8000_0000;
        cur_allowed[2] = '0;
        cur_allowed[3] = '0;
        cur_spoiler[0] = 64'h0000_2080_0000_0000;
        cur_spoiler[1] = 64'h0000_0000_0000_0001;
        cur_spoiler[2] = '1;
        cur_spoiler[3] = '1;
    endtask

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= '0;
        cfg_wdata         <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.char_code <= '0;
        item_ch.line_end  <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        set_text_maps();
        apply_maps();

        // Directed: folding, a repeated word ended by a line end carrying a word byte,
        // a word of maximum length, an overlong word, a spoiled word and empty words.
        send_text("Ab ");
        send_text("aB");
        send_item("a", 1'b1);
        send_text("zyxwvuts");
        send_item(8'h00, 1'b0);
        send_text("zyxwvutsr");
        send_item(8'hFF, 1'b1);
        send_text("a'b");
        send_item(8'hFF, 1'b0);
        send_item(" ", 1'b0);

        random_stretch(180);

        // Every byte joins a word; only line ends and overlong words split.
        for (int i = 0; i < NUM_MAPS; i++) begin
            cur_allowed[i] = '1;
            cur_spoiler[i] = '0;
        end
        apply_maps();
        random_stretch(100);

        // Every byte spoils; no word can ever be submitted.
        for (int i = 0; i < NUM_MAPS; i++) begin
            cur_allowed[i] = '0;
            cur_spoiler[i] = '1;
        end
        apply_maps();
        random_stretch(40);

        // Random maps on top of the text letters, with a stretch free of idle cycles.
        set_text_maps();
        for (int i = 0; i < NUM_MAPS; i++) begin
            cur_allowed[i] = cur_allowed[i] | {$urandom, $urandom};
            cur_spoiler[i] = {$urandom, $urandom};
        end
        apply_maps();
        quiet = 1'b1;
        random_stretch(100);
        quiet = 1'b0;
        random_stretch(50);

        // Back to plain text, by now mostly against a full table.
        set_text_maps();
        apply_maps();
        random_stretch(130);

        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cfuwc_pkg.sv
rtl/core/cfuwc_in_if.sv
rtl/core/cfuwc_out_if.sv
rtl/core/cfuwc_front.sv
rtl/core/cfuwc_fifo.sv
rtl/core/cfuwc_back.sv
rtl/core/class_filtered_unique_word_collector.sv
tb/word_collector_checker.sv
tb/testbench.sv
